@@ sv/swh_pkg.sv @@
// Shared types, constants and functions of the spoke wheel hash unit.
`timescale 1ns / 1ps
package swh_pkg;

   localparam int SPOKES      = 8;
   localparam int BLOCK_BYTES = 16;

   typedef logic [31:0] word_type;
   typedef logic [7:0]  byte_type;

   // One job handed from the front to the back: a 16-byte block, and for
   // the padded closing block the message length in bytes.
   typedef struct packed {
      logic [127:0] block;
      logic         is_final;
      logic [63:0]  length;
   } job_type;

   // Turn counts per phase, as held in the control registers.
   typedef struct packed {
      logic [3:0] blk;
      logic [3:0] fin;
      logic [3:0] sqz;
   } rounds_type;

   typedef enum logic [1:0] {
      CSR_ROUNDS_BLOCK   = 2'd0,
      CSR_ROUNDS_FINAL   = 2'd1,
      CSR_ROUNDS_SQUEEZE = 2'd2
   } csr_index_type;

   localparam logic [3:0] ROUNDS_BLOCK_RST   = 4'd2;
   localparam logic [3:0] ROUNDS_FINAL_RST   = 4'd4;
   localparam logic [3:0] ROUNDS_SQUEEZE_RST = 4'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ABSORB,
      ST_NEXT,
      ST_MIX,
      ST_CONST,
      ST_STEP,
      ST_EMIT
   } back_state_type;

   typedef enum logic [1:0] {
      GRP_BLOCK,
      GRP_FINAL,
      GRP_SQUEEZE
   } group_type;

   // Initial spoke values, the seed phrase read as little-endian words.
   function automatic word_type iv_word(input logic [2:0] idx);
      word_type w;
      case (idx)
         3'd0: w = 32'h6E6C6956;
         3'd1: w = 32'h73756169;
         3'd2: w = 32'h696E7520;
         3'd3: w = 32'h73726576;
         3'd4: w = 32'h74657469;
         3'd5: w = 32'h202C7361;
         3'd6: w = 32'h20544742;
         3'd7: w = 32'h36323032;
         default: w = '0;
      endcase
      return w;
   endfunction

   function automatic word_type rotl32(input word_type x, input logic [4:0] n);
      logic [63:0] dbl;
      dbl = {x, x} << n;
      return dbl[63:32];
   endfunction

   // Round constant for global turn r, modulo 2^32.
   function automatic word_type turn_key(input word_type r);
      word_type odd;
      odd = {r[30:0], 1'b1};
      return iv_word(r[2:0]) * odd + r;
   endfunction

endpackage

@@ sv/spoke_wheel_hash_256_unit.sv @@
// Top level of the spoke wheel hash unit: control registers and the three parts.
// Input words are taken one per cycle while the job queue has room and no padding
// block is pending after a closing word that completes a block. In each turn the back
// end computes a round constant, makes eight spoke steps and checks the phase.
// Reset clears all message state and restores the registers.
`timescale 1ns / 1ps
module spoke_wheel_hash_256_unit #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // data_byte
   input  logic         req_tuser,   // has_byte
   input  logic         req_tlast,   // end_of_message
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [255:0] rsp_tdata,   // digest_part0, part1, part2, part3
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [1:0]   csr_index,
   input  logic [3:0]   csr_data
);
   import swh_pkg::*;

   rounds_type rounds_ff;
   job_type    f_job, q_job;
   logic       f_valid, f_ready, q_valid, q_ready;

   assign csr_ready = 1'b1;

   // Control register writes; unknown indexes are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         rounds_ff.blk <= ROUNDS_BLOCK_RST;
         rounds_ff.fin <= ROUNDS_FINAL_RST;
         rounds_ff.sqz <= ROUNDS_SQUEEZE_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_ROUNDS_BLOCK:   rounds_ff.blk <= csr_data;
            CSR_ROUNDS_FINAL:   rounds_ff.fin <= csr_data;
            CSR_ROUNDS_SQUEEZE: rounds_ff.sqz <= csr_data;
            default: ;
         endcase
      end
   end

   swh_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .job        (f_job),
      .job_valid  (f_valid),
      .job_ready  (f_ready)
   );

   swh_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_job   (f_job),
      .push_valid (f_valid),
      .push_ready (f_ready),
      .pop_job    (q_job),
      .pop_valid  (q_valid),
      .pop_ready  (q_ready)
   );

   swh_back u_back (
      .clock      (clock),
      .reset      (reset),
      .job        (q_job),
      .job_valid  (q_valid),
      .job_ready  (q_ready),
      .rounds     (rounds_ff),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

@@ sv/swh_front.sv @@
// Front end: collects message bytes into blocks, pads the closing block.
`timescale 1ns / 1ps
module swh_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [7:0]       req_tdata,   // data_byte
   input  logic             req_tuser,   // has_byte
   input  logic             req_tlast,   // end_of_message
   output swh_pkg::job_type job,
   output logic             job_valid,
   input  logic             job_ready
);
   import swh_pkg::*;

   byte_type    blk_ff [BLOCK_BYTES];
   logic [3:0]  fill_ff, fill_in;
   logic [63:0] len_ff, len_in;
   logic        pend_ff, pend_in;

   logic        accept, eff_byte, push_full, push_final;
   logic [3:0]  fill_nx;
   logic [63:0] len_nx;
   byte_type    pad;
   byte_type    cur [BLOCK_BYTES];
   logic [127:0] full_blk, last_blk;

   // A closing word that also completes a block leaves a padding block pending.
   assign req_tready = !pend_ff && job_ready;
   assign accept     = req_tvalid && req_tready;
   assign eff_byte   = accept && req_tuser;
   assign push_full  = eff_byte && (fill_ff == 4'hF);
   assign push_final = (pend_ff && job_ready) || (accept && req_tlast && !push_full);
   assign fill_nx    = eff_byte ? fill_ff + 4'd1 : fill_ff;
   assign len_nx     = len_ff + {63'd0, eff_byte};
   assign pad        = 8'(5'd16 - {1'b0, fill_nx});

   // Current block contents including this cycle's byte, and its padded form.
   always_comb begin
      for (int i = 0; i < BLOCK_BYTES; i++) begin
         cur[i] = (eff_byte && fill_ff == 4'(i)) ? req_tdata : blk_ff[i];
         full_blk[8*i +: 8] = cur[i];
         last_blk[8*i +: 8] = (4'(i) < fill_nx) ? cur[i] : pad;
      end
   end

   assign job_valid    = push_full || push_final;
   assign job.block    = push_full ? full_blk : last_blk;
   assign job.is_final = push_final;
   assign job.length   = len_nx;

   // Byte storage, written at the fill position.
   always_ff @(posedge clock) begin
      if (eff_byte) begin
         blk_ff[fill_ff] <= req_tdata;
      end
   end

   // Fill count, length and pending flag.
   always_comb begin
      pend_in = pend_ff;
      fill_in = fill_nx;
      len_in  = len_nx;
      if (push_final) begin
         pend_in = 1'b0;
         fill_in = '0;
         len_in  = '0;
      end else if (accept && req_tlast && push_full) begin
         pend_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
         len_ff  <= '0;
         pend_ff <= 1'b0;
      end else begin
         fill_ff <= fill_in;
         len_ff  <= len_in;
         pend_ff <= pend_in;
      end
   end

endmodule

@@ sv/swh_queue.sv @@
// Short job queue between the front and the back.
`timescale 1ns / 1ps
module swh_queue #(
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  swh_pkg::job_type push_job,
   input  logic             push_valid,
   output logic             push_ready,
   output swh_pkg::job_type pop_job,
   output logic             pop_valid,
   input  logic             pop_ready
);
   import swh_pkg::*;

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   job_type       mem_ff [DEPTH];
   logic [PW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          do_push, do_pop;

   assign push_ready = (cnt_ff != CW'(DEPTH));
   assign pop_valid  = (cnt_ff != '0);
   assign pop_job    = mem_ff[rd_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // Pointer and count update.
   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (do_push) begin
         wr_in = (wr_ff == PW'(DEPTH - 1)) ? '0 : wr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_in = (rd_ff == PW'(DEPTH - 1)) ? '0 : rd_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

@@ sv/swh_back.sv @@
// Back end: absorbs blocks, turns the wheel one spoke per cycle, emits digests.
`timescale 1ns / 1ps
module swh_back (
   input  logic                clock,
   input  logic                reset,
   input  swh_pkg::job_type    job,
   input  logic                job_valid,
   output logic                job_ready,
   input  swh_pkg::rounds_type rounds,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [255:0]        rsp_tdata
);
   import swh_pkg::*;

   back_state_type state_ff, state_in;
   group_type      grp_ff;
   word_type       spk_ff [SPOKES];
   word_type       ring [SPOKES];
   logic [3:0]     turns_ff;
   word_type       tctr_ff, bnum_ff, rc_ff;
   logic [2:0]     step_ff;
   logic [127:0]   half0_ff;
   logic           rsp_valid_ff;
   logic [255:0]   rsp_data_ff;

   logic do_absorb, do_mix, do_const, do_step, last_step;
   logic grp_end, cap_half0, emit_go, pop;
   word_type a_sum, a_rot, a_new, s1_new;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (job_valid) state_in = ST_ABSORB;
         end
         ST_ABSORB: state_in = ST_NEXT;
         ST_MIX:    state_in = ST_NEXT;
         ST_NEXT: begin
            if (turns_ff != '0) begin
               state_in = ST_CONST;
            end else begin
               case (grp_ff)
                  GRP_BLOCK:   state_in = job.is_final ? ST_MIX : ST_IDLE;
                  GRP_FINAL:   state_in = ST_NEXT;
                  GRP_SQUEEZE: state_in = ST_EMIT;
                  default:     state_in = ST_IDLE;
               endcase
            end
         end
         ST_CONST: state_in = ST_STEP;
         ST_STEP: begin
            if (step_ff == 3'd7) state_in = ST_NEXT;
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_tready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Control outputs.
   always_comb begin
      do_absorb = (state_ff == ST_ABSORB);
      do_mix    = (state_ff == ST_MIX);
      do_const  = (state_ff == ST_CONST);
      do_step   = (state_ff == ST_STEP);
      last_step = do_step && (step_ff == 3'd7);
      grp_end   = (state_ff == ST_NEXT) && (turns_ff == '0);
      cap_half0 = grp_end && (grp_ff == GRP_FINAL);
      emit_go   = (state_ff == ST_EMIT) && (!rsp_valid_ff || rsp_tready);
      pop       = emit_go || (grp_end && grp_ff == GRP_BLOCK && !job.is_final);
   end

   assign job_ready  = pop;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // One spoke update; the ring then shifts so the next spoke sits at slot 0.
   always_comb begin
      a_sum  = spk_ff[0] + (spk_ff[1] ^ spk_ff[3]);
      a_rot  = rotl32(a_sum, spk_ff[6][4:0]);
      a_new  = a_rot ^ (spk_ff[6] + rc_ff);
      s1_new = spk_ff[1] + rotl32(a_new, 5'd9);
      ring[0] = s1_new;
      for (int j = 1; j < SPOKES - 1; j++) begin
         ring[j] = spk_ff[j + 1];
      end
      ring[SPOKES - 1] = a_new;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Spoke ring, block number and global turn counter.
   always_ff @(posedge clock) begin
      if (reset || emit_go) begin
         for (int j = 0; j < SPOKES; j++) begin
            spk_ff[j] <= iv_word(3'(j));
         end
         bnum_ff <= 32'd1;
         tctr_ff <= '0;
      end else begin
         if (do_absorb) begin
            for (int j = 0; j < 4; j++) begin
               spk_ff[j] <= spk_ff[j] ^ job.block[32*j +: 32];
            end
            spk_ff[7] <= spk_ff[7] + bnum_ff;
            bnum_ff   <= bnum_ff + 32'd1;
         end
         if (do_mix) begin
            spk_ff[4] <= spk_ff[4] ^ job.length[31:0];
            spk_ff[5] <= spk_ff[5] ^ job.length[63:32];
            spk_ff[6] <= ~spk_ff[6];
         end
         if (do_step) begin
            for (int j = 0; j < SPOKES; j++) begin
               spk_ff[j] <= ring[j];
            end
         end
         if (last_step) begin
            tctr_ff <= tctr_ff + 32'd1;
         end
      end
   end

   // Turn bookkeeping and phase tag.
   always_ff @(posedge clock) begin
      if (reset) begin
         turns_ff <= '0;
         grp_ff   <= GRP_BLOCK;
      end else begin
         if (do_absorb) begin
            turns_ff <= rounds.blk;
            grp_ff   <= GRP_BLOCK;
         end else if (do_mix) begin
            turns_ff <= rounds.fin;
            grp_ff   <= GRP_FINAL;
         end else if (cap_half0) begin
            turns_ff <= rounds.sqz;
            grp_ff   <= GRP_SQUEEZE;
         end else if (last_step) begin
            turns_ff <= turns_ff - 4'd1;
         end
      end
   end

   // Round constant, step index and first digest half.
   always_ff @(posedge clock) begin
      if (do_const) begin
         rc_ff   <= turn_key(tctr_ff);
         step_ff <= '0;
      end else if (do_step) begin
         step_ff <= step_ff + 3'd1;
      end
      if (cap_half0) begin
         half0_ff <= {spk_ff[3], spk_ff[2], spk_ff[1], spk_ff[0]};
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit_go) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (emit_go) begin
         rsp_data_ff <= {spk_ff[3], spk_ff[2], spk_ff[1], spk_ff[0], half0_ff};
      end
   end

endmodule

@@ sv/swh_checker.sv @@
// Port-level checks of the spoke wheel hash unit, bound to the top level.
`timescale 1ns / 1ps
module swh_checker (
   input logic         clock,
   input logic         reset,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [255:0] rsp_tdata,
   input logic         csr_valid,
   input logic         csr_ready
);

   // Reset empties the output register.
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result word still valid after reset");

   // A waiting digest holds until it is taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result word changed or dropped while stalled");

   // A digest leaves only through a handshake or reset.
   a_rsp_drop: assert property (@(posedge clock)
      $fell(rsp_tvalid) |-> $past(rsp_tready) || $past(reset))
      else $error("result word withdrawn without handshake");

   // The control port never stalls outside reset.
   a_csr_ready: assert property (@(posedge clock) disable iff (reset)
      csr_valid |-> csr_ready)
      else $error("control port not ready");

endmodule

bind spoke_wheel_hash_256_unit swh_checker u_swh_checker (.*);
